// ===== design/assert_macros.svh =====
// assertion macros for the key macro sequencer
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define TKM_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also holds through reset
`define TKM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/tkm_pkg.sv =====
// shared types and constants for the key macro sequencer
// no dependencies; used by every module of the block
package tkm_pkg;

    // widths and defaults
    localparam int TKM_TIMER_BITS = 16;
    localparam int CODE_W         = 10;
    localparam int MS_W           = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int MAX_RES        = 3;
    localparam int RES_CNT_W      = 2;

    localparam logic [CODE_W-1:0] TRIGGER_RESET = 10'd57;
    localparam logic [MS_W-1:0]   PRESS_RESET   = 16'd15;
    localparam logic [MS_W-1:0]   DELAY_RESET   = 16'd150;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_CODE = 2'd0,
        CFG_PRESS_MS     = 2'd1,
        CFG_DELAY_MS     = 2'd2
    } cfg_idx_t;

    // item kinds and key values
    localparam logic       MODE_TICK   = 1'b0;
    localparam logic       MODE_KEY    = 1'b1;
    localparam logic [1:0] KEY_RELEASE = 2'd0;
    localparam logic [1:0] KEY_PRESS   = 2'd1;
    localparam logic [1:0] KEY_AUTO    = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_BUTTON = 3'd2,
        PH_DELAY  = 3'd3,
        PH_KEYS   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        TGT_LEFT    = 3'd0,
        TGT_TRIGGER = 3'd1,
        TGT_RSHIFT  = 3'd2,
        TGT_DELETE  = 3'd3,
        TGT_R       = 3'd4
    } tgt_t;

    typedef struct packed {
        logic              mode;
        logic [CODE_W-1:0] key_code;
        logic [1:0]        key_value;
    } in_item_t;

    typedef struct packed {
        tgt_t target;
        logic pressed;
        logic last;
    } out_item_t;

    // one synthetic key action
    typedef struct packed {
        tgt_t target;
        logic pressed;
    } ev_t;

    // all actions caused by one input transaction
    typedef struct packed {
        logic [RES_CNT_W-1:0] count;
        ev_t [MAX_RES-1:0]    ev;
    } step_res_t;

endpackage

// ===== design/triggered_key_macro_sequencer.sv =====
// top level of the key macro sequencer: input register, config registers
// depends on tkm_pkg, tkm_core, tkm_outbuf and assert_macros.svh
//
// usage:
//   s_ takes ticks (mode 0) and key events (mode 1) with valid/ready.
//   m_ returns synthetic key actions; last marks the final action of the
//   input transaction that caused them. A transaction may cause none.
//   cfg_wr_en/cfg_index/cfg_wdata write trigger_code (0), press_ms (1) and
//   delay_ms (2); writes to other indexes are ignored. Write only when idle.
// timing:
//   a transaction lands in the input register and, once the result register
//   is free, is stepped into it, from where its actions are offered on m_.
//   The result register holds one batch at a time: the next transaction is
//   stepped only when it is empty or its last action is being taken, and
//   the input register can hold one more transaction in the meantime.
// reset:
//   idle phase, counter and tap flag clear, registers at their defaults,
//   no pending actions. A stalled m_ready holds the result register and,
//   once the input register is full, drops s_ready.
`include "assert_macros.svh"

module triggered_key_macro_sequencer #(
    parameter int TIMER_BITS = tkm_pkg::TKM_TIMER_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tkm_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tkm_pkg::out_item_t            m_data,
    input  logic                          cfg_wr_en,
    input  logic [tkm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tkm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tkm_pkg::*;

    logic              in_v_reg;
    in_item_t          in_reg;
    logic [CODE_W-1:0] trigger_reg;
    logic [MS_W-1:0]   press_reg;
    logic [MS_W-1:0]   delay_reg;
    logic              go;
    logic              ob_free;
    step_res_t         step_res;
    phase_t            phase;

    // step runs once the result register can take the batch
    assign go      = in_v_reg && ob_free;
    assign s_ready = !in_v_reg || go;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_v_reg <= 1'b1;
        end else if (go) begin
            in_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_reg <= TRIGGER_RESET;
            press_reg   <= PRESS_RESET;
            delay_reg   <= DELAY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TRIGGER_CODE: trigger_reg <= cfg_wdata[CODE_W-1:0];
                CFG_PRESS_MS:     press_reg   <= cfg_wdata[MS_W-1:0];
                CFG_DELAY_MS:     delay_reg   <= cfg_wdata[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tkm_core #(
        .TIMER_BITS(TIMER_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .go          (go),
        .item        (in_reg),
        .trigger_code(trigger_reg),
        .press_ms    (press_reg),
        .delay_ms    (delay_reg),
        .res         (step_res),
        .phase       (phase)
    );

    tkm_outbuf u_outbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (go),
        .res     (step_res),
        .free    (ob_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // checks
    `TKM_ASSERT_CLK(a_input_held, ((in_v_reg && !go) |=> (in_v_reg && $stable(in_reg))), "input register lost a pending transaction")
    `TKM_ASSERT_CLK(a_triple_phase, ((go && step_res.count == 2'd3) |=> (phase == PH_KEYS || phase == PH_IDLE)), "three actions without key phase change")
    `TKM_ASSERT_CLK(a_batch_continues, ((m_valid && m_ready && !m_data.last) |=> m_valid), "batch ended without last")
    `TKM_ASSERT_ALWAYS(a_reset_clears, (!aresetn |=> (!m_valid && phase == PH_IDLE)), "reset left pending actions or active phase")

endmodule

// ===== design/tkm_core.sv =====
// sequencer state and the single-pass step logic for one transaction
// depends on tkm_pkg
module tkm_core #(
    parameter int TIMER_BITS = tkm_pkg::TKM_TIMER_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        go,
    input  tkm_pkg::in_item_t           item,
    input  logic [tkm_pkg::CODE_W-1:0]  trigger_code,
    input  logic [tkm_pkg::MS_W-1:0]    press_ms,
    input  logic [tkm_pkg::MS_W-1:0]    delay_ms,
    output tkm_pkg::step_res_t          res,
    output tkm_pkg::phase_t             phase
);
    import tkm_pkg::*;

    localparam int CMP_W = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic                  tapped_reg, tapped_next;

    logic [TIMER_BITS-1:0] elapsed_pre;
    phase_t                phase_pre;
    logic                  skip_step;
    logic                  is_trigger;
    logic [CMP_W-1:0]      elapsed_cmp;
    logic                  press_done;
    logic                  delay_done;

    assign is_trigger = (item.mode == MODE_KEY) && (item.key_code == trigger_code);

    // saturating tick count
    always_comb begin
        elapsed_pre = elapsed_reg;
        if (item.mode == MODE_TICK && !(&elapsed_reg)) begin
            elapsed_pre = TIMER_BITS'(elapsed_reg + 1'b1);
        end
    end

    assign elapsed_cmp = CMP_W'(elapsed_pre);
    assign press_done  = elapsed_cmp >= CMP_W'(press_ms);
    assign delay_done  = elapsed_cmp >= CMP_W'(delay_ms);

    // trigger key handling, then one sequence step
    always_comb begin
        phase_pre    = phase_reg;
        tapped_next  = tapped_reg;
        skip_step    = 1'b0;
        res          = '0;
        if (is_trigger) begin
            case (item.key_value)
                KEY_PRESS: begin
                    tapped_next = 1'b1;
                end
                KEY_RELEASE: begin
                    if (tapped_reg) begin
                        phase_pre = PH_START;
                        skip_step = 1'b1;
                    end else begin
                        // interrupt: release button and trigger
                        phase_pre        = PH_IDLE;
                        res.count        = 2'd2;
                        res.ev[0].target = TGT_LEFT;
                        res.ev[1].target = TGT_TRIGGER;
                    end
                end
                KEY_AUTO: begin
                    if (phase_reg == PH_IDLE) begin
                        tapped_next = 1'b0;
                        phase_pre   = PH_START;
                    end
                end
                default: begin
                end
            endcase
        end

        phase_next   = phase_pre;
        elapsed_next = elapsed_pre;
        if (!skip_step) begin
            case (phase_pre)
                PH_START: begin
                    res.count         = 2'd1;
                    res.ev[0].target  = TGT_LEFT;
                    res.ev[0].pressed = 1'b1;
                    elapsed_next      = '0;
                    phase_next        = PH_BUTTON;
                end
                PH_BUTTON: begin
                    if (press_done) begin
                        res.count         = 2'd1;
                        res.ev[0].target  = TGT_LEFT;
                        res.ev[0].pressed = 1'b0;
                        elapsed_next      = '0;
                        phase_next        = PH_DELAY;
                    end
                end
                PH_DELAY: begin
                    if (delay_done) begin
                        res.count         = 2'd3;
                        res.ev[0].target  = TGT_RSHIFT;
                        res.ev[1].target  = TGT_DELETE;
                        res.ev[2].target  = TGT_R;
                        res.ev[0].pressed = 1'b1;
                        res.ev[1].pressed = 1'b1;
                        res.ev[2].pressed = 1'b1;
                        elapsed_next      = '0;
                        phase_next        = PH_KEYS;
                    end
                end
                PH_KEYS: begin
                    if (press_done) begin
                        res.count         = 2'd3;
                        res.ev[0].target  = TGT_R;
                        res.ev[1].target  = TGT_DELETE;
                        res.ev[2].target  = TGT_RSHIFT;
                        elapsed_next      = '0;
                        phase_next        = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // state registers, updated once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            tapped_reg  <= 1'b0;
        end else if (go) begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            tapped_reg  <= tapped_next;
        end
    end

    assign phase = phase_reg;

endmodule

// ===== design/tkm_outbuf.sv =====
// result register: holds up to three actions and hands them out one per cycle while m_ready is high
// depends on tkm_pkg
module tkm_outbuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  tkm_pkg::step_res_t  res,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output tkm_pkg::out_item_t  m_data
);
    import tkm_pkg::*;

    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;
    ev_t [MAX_RES-1:0]    ev_reg, ev_next;
    logic                 pop;

    assign m_valid = (cnt_reg != '0);
    assign pop     = m_valid && m_ready;
    // empty now, or emptied by the transaction leaving this cycle
    assign free    = (cnt_reg == '0) || ((cnt_reg == RES_CNT_W'(1)) && m_ready);

    // load a new batch or shift the next action to the head
    always_comb begin
        cnt_next = cnt_reg;
        ev_next  = ev_reg;
        if (load) begin
            cnt_next = res.count;
            ev_next  = res.ev;
        end else if (pop) begin
            cnt_next  = RES_CNT_W'(cnt_reg - 1'b1);
            ev_next[0] = ev_reg[1];
            ev_next[1] = ev_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_reg <= ev_next;
    end

    assign m_data.target  = ev_reg[0].target;
    assign m_data.pressed = ev_reg[0].pressed;
    assign m_data.last    = (cnt_reg == RES_CNT_W'(1));

endmodule

// ===== verif/triggered_key_macro_sequencer_test.sv =====
// self-checking testbench for the triggered key macro sequencer
// depends on tkm_pkg and the triggered_key_macro_sequencer top level
// drives ticks and key events, predicts the synthetic key actions, checks each one
module triggered_key_macro_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tkm_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLDOFF_LEN   = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    triggered_key_macro_sequencer #(.TIMER_BITS(TKM_TIMER_BITS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // mirror of the block's settings and sequence state
    logic [CODE_W-1:0]         mirror_trigger = TRIGGER_RESET;
    logic [MS_W-1:0]           mirror_press_ms = PRESS_RESET;
    logic [MS_W-1:0]           mirror_delay_ms = DELAY_RESET;
    phase_t                    mirror_phase = PH_IDLE;
    logic [TKM_TIMER_BITS-1:0] mirror_elapsed = '0;
    logic                      mirror_tapped = 1'b0;

    out_item_t pending_key_actions[$];
    out_item_t step_actions[$];

    int err_count = 0;
    int items_sent = 0;
    int actions_checked = 0;
    int settings_used = 0;

    // sender pacing
    bit offering = 0;
    bit steady_sender = 0;
    int burst_left = 0;

    // receiver pacing
    int unsigned holdoff_req = 0;
    int unsigned holdoff_left = 0;
    int unsigned rx_style = 0;
    int unsigned rx_style_left = 0;
    int unsigned rx_phase_cnt = 0;

    function automatic void add_action(input tgt_t target, input logic pressed);
        out_item_t act;
        act.target = target;
        act.pressed = pressed;
        act.last = 1'b0;
        step_actions.push_back(act);
    endfunction

    // one sequence step on the mirrored state
    function automatic void advance_sequence();
        case (mirror_phase)
            PH_START: begin
                add_action(TGT_LEFT, 1'b1);
                mirror_elapsed = '0;
                mirror_phase = PH_BUTTON;
            end
            PH_BUTTON: begin
                if (mirror_elapsed >= mirror_press_ms) begin
                    add_action(TGT_LEFT, 1'b0);
                    mirror_elapsed = '0;
                    mirror_phase = PH_DELAY;
                end
            end
            PH_DELAY: begin
                if (mirror_elapsed >= mirror_delay_ms) begin
                    add_action(TGT_RSHIFT, 1'b1);
                    add_action(TGT_DELETE, 1'b1);
                    add_action(TGT_R, 1'b1);
                    mirror_elapsed = '0;
                    mirror_phase = PH_KEYS;
                end
            end
            PH_KEYS: begin
                if (mirror_elapsed >= mirror_press_ms) begin
                    add_action(TGT_R, 1'b0);
                    add_action(TGT_DELETE, 1'b0);
                    add_action(TGT_RSHIFT, 1'b0);
                    mirror_elapsed = '0;
                    mirror_phase = PH_IDLE;
                end
            end
            default: begin
                mirror_phase = PH_IDLE;
            end
        endcase
    endfunction

    // key actions caused by one accepted transaction
    function automatic void predict_key_actions(input in_item_t item);
        bit skip_step;
        skip_step = 0;
        step_actions.delete();
        if (item.mode == MODE_TICK) begin
            if (mirror_elapsed != '1) mirror_elapsed = mirror_elapsed + 1'b1;
        end else if (item.key_code == mirror_trigger) begin
            case (item.key_value)
                KEY_PRESS: begin
                    mirror_tapped = 1'b1;
                end
                KEY_RELEASE: begin
                    if (mirror_tapped) begin
                        mirror_phase = PH_START;
                        skip_step = 1;
                    end else begin
                        // interrupt: release button and trigger, even from idle
                        mirror_phase = PH_IDLE;
                        add_action(TGT_LEFT, 1'b0);
                        add_action(TGT_TRIGGER, 1'b0);
                    end
                end
                KEY_AUTO: begin
                    if (mirror_phase == PH_IDLE) begin
                        mirror_tapped = 1'b0;
                        mirror_phase = PH_START;
                    end
                end
                default: ;
            endcase
        end
        if (!skip_step) advance_sequence();
        if (step_actions.size() > 0) step_actions[step_actions.size() - 1].last = 1'b1;
        foreach (step_actions[i]) pending_key_actions.push_back(step_actions[i]);
    endfunction

    function automatic in_item_t make_tick();
        in_item_t item;
        item.mode = MODE_TICK;
        item.key_code = CODE_W'($urandom_range(0, 1023));
        item.key_value = 2'($urandom_range(0, 3));
        return item;
    endfunction

    function automatic in_item_t make_key(input logic [CODE_W-1:0] code,
                                          input logic [1:0] value);
        in_item_t item;
        item.mode = MODE_KEY;
        item.key_code = code;
        item.key_value = value;
        return item;
    endfunction

    // offer one transaction, pacing in bursts, and predict it on acceptance
    task automatic send_item(input in_item_t item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = steady_sender ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                if (offering) begin
                    s_valid <= 1'b0;
                    offering = 0;
                end
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_data <= item;
        if (!offering) begin
            s_valid <= 1'b1;
            offering = 1;
        end
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_key_actions(item);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(make_tick());
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_tick();
    endtask

    task automatic send_key(input logic [CODE_W-1:0] code, input logic [1:0] value);
        send_item(make_key(code, value));
    endtask

    // sender goes quiet until every expected action is out and the pipe is empty
    task automatic wait_idle();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 0;
        end
        while (pending_key_actions.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write all registers plus one ignored index; only while idle
    task automatic apply_settings(input logic [CODE_W-1:0] trig,
                                  input logic [MS_W-1:0] press,
                                  input logic [MS_W-1:0] delay);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TRIGGER_CODE;
        cfg_wdata <= CFG_DATA_W'(trig);
        @(posedge aclk);
        mirror_trigger = trig;
        cfg_index <= CFG_PRESS_MS;
        cfg_wdata <= press;
        @(posedge aclk);
        mirror_press_ms = press;
        cfg_index <= CFG_DELAY_MS;
        cfg_wdata <= delay;
        @(posedge aclk);
        mirror_delay_ms = delay;
        cfg_index <= CFG_UNUSED_IDX;
        cfg_wdata <= CFG_DATA_W'($urandom_range(0, 65535));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // a mix of taps, holds, tick runs and stray key events
    task automatic random_sequences(input int count);
        int target_count;
        int choice;
        int repeats;
        target_count = items_sent + count;
        while (items_sent < target_count) begin
            choice = $urandom_range(0, 99);
            if (choice < 30) begin
                send_ticks($urandom_range(1, 6));
            end else if (choice < 45) begin
                send_key(mirror_trigger, KEY_PRESS);
                if ($urandom_range(0, 1)) send_tick();
                send_key(mirror_trigger, KEY_RELEASE);
            end else if (choice < 62) begin
                repeats = $urandom_range(1, 4);
                repeat (repeats) begin
                    send_key(mirror_trigger, KEY_AUTO);
                    send_ticks($urandom_range(0, 3));
                end
                if ($urandom_range(0, 1)) send_key(mirror_trigger, KEY_RELEASE);
            end else if (choice < 77) begin
                send_key(CODE_W'($urandom_range(0, 767)), 2'($urandom_range(0, 3)));
            end else if (choice < 87) begin
                send_key(mirror_trigger, 2'($urandom_range(0, 3)));
            end else begin
                send_ticks($urandom_range(5, 15));
            end
        end
    endtask

    // default settings straight out of reset: one tap runs the first half
    task automatic test_default_tap();
        send_key(10'd30, KEY_PRESS);
        send_key(TRIGGER_RESET, KEY_PRESS);
        send_key(TRIGGER_RESET, KEY_RELEASE);
        send_ticks(16);
        send_key(TRIGGER_RESET, 2'd3);
        send_key(10'd58, KEY_RELEASE);
        wait_idle();
    endtask

    // zero and maximum timing, trigger codes 0 and 767
    task automatic test_extreme_settings();
        apply_settings(10'd0, 16'd0, 16'd0);
        steady_sender = 1;
        send_key(10'd0, KEY_AUTO);
        send_ticks(3);
        send_key(10'd0, KEY_AUTO);
        send_key(10'd0, KEY_RELEASE);
        // interrupt while idle still emits both releases
        send_key(10'd0, KEY_RELEASE);
        send_key(10'd0, 2'd3);
        send_key(10'd767, KEY_PRESS);
        send_key(10'd767, KEY_AUTO);
        send_key(10'd767, KEY_RELEASE);
        steady_sender = 0;
        wait_idle();
        apply_settings(10'd767, 16'hFFFF, 16'hFFFF);
        send_key(10'd767, KEY_PRESS);
        send_key(10'd767, KEY_RELEASE);
        send_ticks(4);
        send_key(10'd767, KEY_AUTO);
        send_key(10'd767, 2'd3);
        send_key(10'd0, KEY_AUTO);
        wait_idle();
    endtask

    // several random settings, each with a stretch of random sequences
    task automatic test_random_sequences();
        logic [CODE_W-1:0] trig;
        logic [MS_W-1:0] press;
        logic [MS_W-1:0] delay;
        for (int phase_idx = 0; phase_idx < 6; phase_idx++) begin
            trig = CODE_W'($urandom_range(0, 767));
            press = MS_W'($urandom_range(0, 5));
            delay = MS_W'($urandom_range(0, 8));
            if (phase_idx == 5) delay = MS_W'($urandom_range(15, 25));
            apply_settings(trig, press, delay);
            steady_sender = (phase_idx == 2);
            random_sequences(15);
            wait_idle();
        end
        steady_sender = 0;
    endtask

    // receiver holds off long enough to back the block up into its input
    task automatic test_output_backpressure();
        apply_settings(CODE_W'($urandom_range(0, 767)), 16'd0, 16'd0);
        steady_sender = 1;
        holdoff_req = HOLDOFF_LEN;
        repeat (8) begin
            send_key(mirror_trigger, KEY_AUTO);
            send_ticks(3);
        end
        steady_sender = 0;
        wait_idle();
        send_key(mirror_trigger, KEY_AUTO);
        send_ticks(3);
        send_key(mirror_trigger, KEY_RELEASE);
        wait_idle();
    endtask

    // receiver: long hold-off on request, otherwise changing stall styles
    always @(posedge aclk) begin
        if (holdoff_req != 0) begin
            holdoff_left = holdoff_req;
            holdoff_req = 0;
        end
        if (rx_style_left == 0) begin
            rx_style = $urandom_range(0, 2);
            rx_style_left = $urandom_range(20, 80);
        end else begin
            rx_style_left--;
        end
        rx_phase_cnt++;
        if (holdoff_left != 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_style)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= (rx_phase_cnt % 5 >= 2);
            endcase
        end
    end

    // compare each accepted action with the oldest prediction
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            actions_checked++;
            if (pending_key_actions.size() == 0) begin
                $error("unexpected key action: target %0d pressed %0d last %0d",
                       m_data.target, m_data.pressed, m_data.last);
                err_count++;
            end else begin
                want = pending_key_actions.pop_front();
                if (m_data.target !== want.target) begin
                    $error("target: expected %0d, actual %0d", want.target, m_data.target);
                    err_count++;
                end
                if (m_data.pressed !== want.pressed) begin
                    $error("pressed: expected %0d, actual %0d", want.pressed, m_data.pressed);
                    err_count++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_data.last);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        int idle_cycles;
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_tap();
        test_extreme_settings();
        test_random_sequences();
        test_output_backpressure();
        $display("run covered %0d transactions in, %0d key actions checked, %0d settings",
                 items_sent, actions_checked, settings_used);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== triggered_key_macro_sequencer.f =====
+incdir+design
design/tkm_pkg.sv
design/tkm_core.sv
design/tkm_outbuf.sv
design/triggered_key_macro_sequencer.sv
verif/triggered_key_macro_sequencer_test.sv
